// ===== rtl/i2p_pkg.sv =====
package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_TIMES  = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DIVIDE = 8'h2f;
    localparam logic [7:0] CH_SEMI   = 8'h3b;

    typedef enum logic [2:0] {
        OP_LPAREN = 3'd0,
        OP_PLUS   = 3'd1,
        OP_MINUS  = 3'd2,
        OP_TIMES  = 3'd3,
        OP_DIVIDE = 3'd4
    } op_code_t;

    localparam int OP_W = $bits(op_code_t);

    function automatic logic [7:0] code_char(input logic [OP_W-1:0] code);
        logic [7:0] ch;
        case (code)
            OP_PLUS:   ch = CH_PLUS;
            OP_MINUS:  ch = CH_MINUS;
            OP_TIMES:  ch = CH_TIMES;
            OP_DIVIDE: ch = CH_DIVIDE;
            default:   ch = CH_LPAREN;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/infix_to_postfix_converter.sv =====
// Shunting-yard infix to postfix converter, one character word in, zero or more
// character words out. The operator stack sits in a single-port-read RAM with a
// registered read, so every stack pop passes through S_RD, which issues the
// address, and then S_CHK, which checks the word read. An ordinary character, a
// space or '(' is handled in S_IDLE alone; an operator, ')' or terminator goes
// through S_RD and S_CHK for each word it pops off the stack and for any entry
// or matching '(' that it stops on, then ends in S_FIN. Output stalls can add
// waits in S_IDLE, S_CHK and S_FIN. The last word caused by an input carries
// run_last; a terminator ends with a zero word that reports overflow_seen when a
// push onto a full stack was dropped.
module infix_to_postfix_converter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       overflow_seen
);

    import i2p_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        K_TERM,
        K_RPAR,
        K_ADD,
        K_MUL
    } kind_t;

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    op_code_t          op_reg, op_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_flag_reg, ovf_flag_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_char_reg, pend_char_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic              run_last_reg, run_last_next;
    logic              ovf_out_reg, ovf_out_next;

    logic              out_free;
    logic [CNT_W-1:0]  cnt_dec;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [OP_W-1:0]   rd_data;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [OP_W-1:0]   wr_data;
    op_code_t          top_op;
    logic              do_pop;
    logic              stack_full;

    i2p_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (OP_W)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign cnt_dec    = count_reg - 1'b1;
    assign rd_addr    = cnt_dec[PTR_W-1:0];
    assign wr_addr    = count_reg[PTR_W-1:0];
    assign stack_full = (count_reg == CNT_W'(STACK_DEPTH));
    assign top_op     = op_code_t'(rd_data);
    assign in_ready   = (state_reg == S_IDLE) && out_free;

    always_comb
    begin
        case (kind_reg)
            K_TERM:  do_pop = 1'b1;
            K_RPAR:  do_pop = (top_op != OP_LPAREN);
            K_ADD:   do_pop = (top_op != OP_LPAREN);
            K_MUL:   do_pop = (top_op == OP_TIMES) || (top_op == OP_DIVIDE);
            default: do_pop = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        ovf_flag_next   = ovf_flag_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_char_next   = out_char_reg;
        run_last_next   = run_last_reg;
        ovf_out_next    = ovf_out_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_data         = OP_LPAREN;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (in_char) inside
                        CH_NUL, CH_SEMI, CH_LF:
                        begin
                            kind_next  = K_TERM;
                            state_next = S_RD;
                        end
                        CH_SPACE:
                        begin
                        end
                        CH_LPAREN:
                        begin
                            if (stack_full)
                            begin
                                ovf_flag_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_data    = OP_LPAREN;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CH_RPAREN:
                        begin
                            kind_next  = K_RPAR;
                            state_next = S_RD;
                        end
                        CH_PLUS, CH_MINUS:
                        begin
                            kind_next       = K_ADD;
                            op_next         = (in_char == CH_PLUS) ? OP_PLUS : OP_MINUS;
                            pend_valid_next = 1'b1;
                            pend_char_next  = CH_SPACE;
                            state_next      = S_RD;
                        end
                        CH_TIMES, CH_DIVIDE:
                        begin
                            kind_next       = K_MUL;
                            op_next         = (in_char == CH_TIMES) ? OP_TIMES : OP_DIVIDE;
                            pend_valid_next = 1'b1;
                            pend_char_next  = CH_SPACE;
                            state_next      = S_RD;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = in_char;
                            run_last_next  = 1'b1;
                            ovf_out_next   = 1'b0;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                if (kind_reg == K_RPAR && top_op == OP_LPAREN)
                begin
                    // matching '(' is dropped
                    count_next = cnt_dec;
                    state_next = S_FIN;
                end
                else if (do_pop)
                begin
                    // read data holds while stalled: no new read is issued
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = pend_char_reg;
                            run_last_next  = 1'b0;
                            ovf_out_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_char_next  = code_char(rd_data);
                        count_next      = cnt_dec;
                        state_next      = S_RD;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (kind_reg == K_TERM)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_char_next   = pend_char_reg;
                            run_last_next   = 1'b0;
                            ovf_out_next    = 1'b0;
                            pend_valid_next = 1'b0;
                        end
                        else
                        begin
                            out_char_next = CH_NUL;
                            run_last_next = 1'b1;
                            ovf_out_next  = ovf_flag_reg;
                            count_next    = '0;
                            ovf_flag_next = 1'b0;
                            state_next    = S_IDLE;
                        end
                    end
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // held word is the last one of this input
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = pend_char_reg;
                        run_last_next  = 1'b1;
                        ovf_out_next   = 1'b0;
                    end
                    pend_valid_next = 1'b0;
                    if (kind_reg != K_RPAR)
                    begin
                        if (stack_full)
                        begin
                            ovf_flag_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_data    = op_reg;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= K_TERM;
            op_reg         <= OP_LPAREN;
            count_reg      <= '0;
            ovf_flag_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_char_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_char_reg   <= '0;
            run_last_reg   <= 1'b0;
            ovf_out_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            op_reg         <= op_next;
            count_reg      <= count_next;
            ovf_flag_reg   <= ovf_flag_next;
            pend_valid_reg <= pend_valid_next;
            pend_char_reg  <= pend_char_next;
            out_valid_reg  <= out_valid_next;
            out_char_reg   <= out_char_next;
            run_last_reg   <= run_last_next;
            ovf_out_reg    <= ovf_out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_char      = out_char_reg;
    assign run_last      = run_last_reg;
    assign overflow_seen = ovf_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_ovf_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ovf_out_reg |-> out_char_reg == CH_NUL && run_last_reg)
        else $error("overflow reported on a non-terminator word");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHK |-> $past(state_reg) == S_RD || $past(state_reg) == S_CHK)
        else $error("stack check without a prior read");

    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("held word left behind at end of input");

endmodule

// ===== rtl/i2p_ram.sv =====
module i2p_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 3
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
